@@ sv/dgbt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgbt_pkg
// Shared widths, constants, types and depth checks of the depth grid
// body triangulator.
// ----------------------------------------------------------------------------
package dgbt_pkg;

    // Field widths
    localparam int IDX_W      = 18;   // pixel index
    localparam int DEPTH_W    = 16;   // signed depth in mm
    localparam int SAMPLE_W   = DEPTH_W + 1;  // body flag over depth
    localparam int BODY_IN_W  = 8;
    localparam int BODY_W     = 3;
    localparam int MAXD_W     = 15;
    localparam int STEP_W     = 7;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 9;

    // Image and line store geometry
    localparam int IMAGE_WIDTH = 512;
    localparam int LINE_DEPTH  = 512;
    localparam int LINE_AW     = $clog2(LINE_DEPTH);

    // Result queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = Q_AW + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_BODY    = 2'd0,
        REG_MAX_DEPTH_STEP = 2'd1,
        REG_GRID_STEP      = 2'd2,
        REG_GRID_COLUMNS   = 2'd3
    } cfg_reg_t;

    localparam logic [BODY_W-1:0] TARGET_BODY_RST    = 3'd0;
    localparam logic [MAXD_W-1:0] MAX_DEPTH_STEP_RST = 15'd100;
    localparam logic [STEP_W-1:0] GRID_STEP_RST      = 7'd1;
    localparam logic [COL_W-1:0]  GRID_COLUMNS_RST   = 10'd512;

    // One triangle as three pixel indices
    typedef struct packed {
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
    } tri_t;

    // Up to two triangles made by one sample
    typedef struct packed {
        logic v0;
        tri_t t0;
        logic v1;
        tri_t t1;
    } tri_pair_t;

    // One queued result
    typedef struct packed {
        tri_t corners;
        logic last;
    } out_item_t;

    // |a - b| strictly below the bound
    function automatic logic depth_close(
        input logic signed [DEPTH_W-1:0] a,
        input logic signed [DEPTH_W-1:0] b,
        input logic [MAXD_W-1:0]         maxd
    );
        logic signed [DEPTH_W:0] d;
        logic [DEPTH_W:0]        mag;
        begin
            d   = (DEPTH_W+1)'(a) - (DEPTH_W+1)'(b);
            mag = d[DEPTH_W] ? (DEPTH_W+1)'(-d) : (DEPTH_W+1)'(d);
            return mag < (DEPTH_W+1)'(maxd);
        end
    endfunction

    function automatic logic depth_pos(input logic [SAMPLE_W-1:0] s);
        begin
            return !s[DEPTH_W-1] && (s[DEPTH_W-1:0] != '0);
        end
    endfunction

    // All corners positive, both steps from first corner below the bound
    function automatic logic tri_ok(
        input logic [SAMPLE_W-1:0] p,
        input logic [SAMPLE_W-1:0] q,
        input logic [SAMPLE_W-1:0] r,
        input logic [MAXD_W-1:0]   maxd
    );
        begin
            return depth_pos(p) && depth_pos(q) && depth_pos(r)
                && depth_close(signed'(p[DEPTH_W-1:0]), signed'(q[DEPTH_W-1:0]), maxd)
                && depth_close(signed'(p[DEPTH_W-1:0]), signed'(r[DEPTH_W-1:0]), maxd);
        end
    endfunction

endpackage

@@ sv/dgbt_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgbt channel interfaces
// Sample input, triangle output and configuration write channels, each a
// valid/ready request channel with source and sink modports.
// ----------------------------------------------------------------------------
interface dgbt_sample_if import dgbt_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       frame_start;
    logic [BODY_IN_W-1:0]       body_index;
    logic signed [DEPTH_W-1:0]  depth_z;

    modport source (output valid, output frame_start, output body_index,
                    output depth_z, input ready);
    modport sink   (input valid, input frame_start, input body_index,
                    input depth_z, output ready);
endinterface

interface dgbt_tri_if import dgbt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  corner_a;
    logic [IDX_W-1:0]  corner_b;
    logic [IDX_W-1:0]  corner_c;
    logic              last;

    modport source (output valid, output corner_a, output corner_b,
                    output corner_c, output last, input ready);
    modport sink   (input valid, input corner_a, input corner_b,
                    input corner_c, input last, output ready);
endinterface

interface dgbt_cfg_if import dgbt_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/depth_grid_body_triangulator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_grid_body_triangulator
// Grid samples of a depth frame in, body triangles as pixel-index triples out.
// ----------------------------------------------------------------------------
// Takes one grid sample per clock in raster order while the result queue has
// room for two entries; frame_start restarts row, column and row base. The
// single-port line store is read and written once per sample (old entry out,
// new entry in), which sets the rate at one sample per cycle. A triangle is
// queued when the evaluation stage advances. A sample that makes two
// triangles fills two queue entries, so input slows to the output rate when
// the four-entry result queue has fewer than two free entries. The line
// store needs no clearing after reset. Configuration is always accepted and
// must only be written while the block is idle.
// ----------------------------------------------------------------------------
module depth_grid_body_triangulator import dgbt_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    dgbt_sample_if.sink  sample,
    dgbt_tri_if.source   triangle,
    dgbt_cfg_if.sink     cfg
);

    localparam logic [IDX_W-1:0] IMG_W_IDX = IDX_W'(IMAGE_WIDTH);

    // Configuration registers
    logic [BODY_W-1:0]   target_body_reg;
    logic [MAXD_W-1:0]   max_depth_step_reg;
    logic [STEP_W-1:0]   grid_step_reg;
    logic [COL_W-1:0]    grid_columns_reg;

    // Grid position of the next sample
    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_next;
    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    row_next;
    logic [IDX_W-1:0]    base_reg;
    logic [IDX_W-1:0]    base_next;

    // Evaluation stage
    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic                s1_inner_reg;
    logic [SAMPLE_W-1:0] s1_cur_reg;
    logic [SAMPLE_W-1:0] s1_left_reg;
    logic [SAMPLE_W-1:0] s1_tl_reg;
    logic [COL_W-1:0]    s1_col_reg;
    logic [IDX_W-1:0]    s1_base_reg;

    logic                accept;
    logic                s1_advance;
    logic                room2;
    logic [COL_W-1:0]    col_cur;
    logic [ROW_W-1:0]    row_cur;
    logic [IDX_W-1:0]    base_cur;
    logic                row_wrap;
    logic [IDX_W-1:0]    row_up;
    logic [SAMPLE_W-1:0] cur;
    logic [SAMPLE_W-1:0] top;
    tri_pair_t           tris;
    out_item_t           out_item;

    // Configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_body_reg    <= TARGET_BODY_RST;
            max_depth_step_reg <= MAX_DEPTH_STEP_RST;
            grid_step_reg      <= GRID_STEP_RST;
            grid_columns_reg   <= GRID_COLUMNS_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_TARGET_BODY:    target_body_reg    <= cfg.data[BODY_W-1:0];
                REG_MAX_DEPTH_STEP: max_depth_step_reg <= cfg.data[MAXD_W-1:0];
                REG_GRID_STEP:      grid_step_reg      <= cfg.data[STEP_W-1:0];
                REG_GRID_COLUMNS:   grid_columns_reg   <= cfg.data[COL_W-1:0];
                default:            ;
            endcase
        end
    end

    // Handshake: a new sample enters when the evaluation stage frees up
    assign s1_advance   = s1_valid_reg && room2;
    assign sample.ready = !s1_valid_reg || s1_advance;
    assign accept       = sample.valid && sample.ready;

    // Sample word: body flag over depth bits
    assign cur = {(sample.body_index == BODY_IN_W'(target_body_reg)),
                  sample.depth_z};

    assign row_up = IDX_W'(IMG_W_IDX * IDX_W'(grid_step_reg));

    // Grid position, with restart on frame start and row wrap
    always_comb
    begin
        col_cur  = sample.frame_start ? '0 : col_reg;
        row_cur  = sample.frame_start ? '0 : row_reg;
        base_cur = sample.frame_start ? '0 : base_reg;
        row_wrap = ((COL_W+1)'(col_cur) + (COL_W+1)'(1)) >= (COL_W+1)'(grid_columns_reg);

        col_next  = col_reg;
        row_next  = row_reg;
        base_next = base_reg;
        if (accept)
        begin
            if (row_wrap)
            begin
                col_next  = '0;
                row_next  = row_cur + ROW_W'(1);
                base_next = base_cur + row_up;
            end
            else
            begin
                col_next  = col_cur + COL_W'(1);
                row_next  = row_cur;
                base_next = base_cur;
            end
        end
        s1_valid_next = accept || (s1_valid_reg && !s1_advance);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            base_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s1_cur_reg   <= '0;
            s1_left_reg  <= '0;
            s1_tl_reg    <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            base_reg     <= base_next;
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                // left and top-left are the previous sample and its top
                s1_cur_reg  <= cur;
                s1_left_reg <= s1_cur_reg;
                s1_tl_reg   <= top;
            end
        end
    end

    // Position payload of the evaluation stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_inner_reg <= (col_cur != '0) && (row_cur != '0);
            s1_col_reg   <= col_cur;
            s1_base_reg  <= base_cur;
        end
    end

    dgbt_line_store u_line_store (
        .clk     (clk),
        .en      (accept),
        .addr    (col_cur[LINE_AW-1:0]),
        .wr_data (cur),
        .rd_data (top)
    );

    dgbt_tri_eval u_tri_eval (
        .inner      (s1_inner_reg),
        .s_cur      (s1_cur_reg),
        .s_top      (top),
        .s_left     (s1_left_reg),
        .s_tl       (s1_tl_reg),
        .pixel_base (s1_base_reg),
        .column     (s1_col_reg),
        .grid_step  (grid_step_reg),
        .row_up     (row_up),
        .max_step   (max_depth_step_reg),
        .tris       (tris)
    );

    dgbt_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_advance),
        .tris      (tris),
        .room2     (room2),
        .out_valid (triangle.valid),
        .out_ready (triangle.ready),
        .out_item  (out_item)
    );

    assign triangle.corner_a = out_item.corners.a;
    assign triangle.corner_b = out_item.corners.b;
    assign triangle.corner_c = out_item.corners.c;
    assign triangle.last     = out_item.last;

endmodule

@@ sv/dgbt_line_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgbt_line_store
// Previous grid row store: body flag and depth per column. One access per
// sample reads the old entry and writes the new one at the same address.
// ----------------------------------------------------------------------------
module dgbt_line_store import dgbt_pkg::*; (
    input  logic                clk,
    input  logic                en,
    input  logic [LINE_AW-1:0]  addr,
    input  logic [SAMPLE_W-1:0] wr_data,
    output logic [SAMPLE_W-1:0] rd_data
);

    logic [SAMPLE_W-1:0] mem [LINE_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    // Read-before-write: the read returns the entry of the previous row
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_data_reg <= mem[addr];
            mem[addr]   <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/dgbt_tri_eval.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgbt_tri_eval
// Corner indices and triangle selection for one sample from its top, left
// and top-left neighbors.
// ----------------------------------------------------------------------------
module dgbt_tri_eval import dgbt_pkg::*; (
    input  logic                inner,     // not first row, not first column
    input  logic [SAMPLE_W-1:0] s_cur,
    input  logic [SAMPLE_W-1:0] s_top,
    input  logic [SAMPLE_W-1:0] s_left,
    input  logic [SAMPLE_W-1:0] s_tl,
    input  logic [IDX_W-1:0]    pixel_base,
    input  logic [COL_W-1:0]    column,
    input  logic [STEP_W-1:0]   grid_step,
    input  logic [IDX_W-1:0]    row_up,    // IMAGE_WIDTH * grid_step
    input  logic [MAXD_W-1:0]   max_step,
    output tri_pair_t           tris
);

    localparam int PROD_W = COL_W + STEP_W;

    logic [PROD_W-1:0] col_off;
    logic [IDX_W-1:0]  idx_i;
    logic [IDX_W-1:0]  idx_t;
    logic [IDX_W-1:0]  idx_l;
    logic [IDX_W-1:0]  idx_tl;
    logic              b_i;
    logic              b_t;
    logic              b_l;
    logic              b_tl;

    // Corner pixel indices, modulo the index width
    assign col_off = PROD_W'(column) * PROD_W'(grid_step);
    assign idx_i   = pixel_base + IDX_W'(col_off);
    assign idx_t   = idx_i - row_up;
    assign idx_l   = idx_i - IDX_W'(grid_step);
    assign idx_tl  = idx_l - row_up;

    assign b_i  = s_cur[SAMPLE_W-1];
    assign b_t  = s_top[SAMPLE_W-1];
    assign b_l  = s_left[SAMPLE_W-1];
    assign b_tl = s_tl[SAMPLE_W-1];

    // Triangle choice by which diagonal corners are body
    always_comb
    begin
        tris = '0;
        if (inner)
        begin
            if (b_i && !b_tl)
            begin
                tris.v0 = b_t && b_l && tri_ok(s_cur, s_top, s_left, max_step);
                tris.t0 = '{a: idx_i, b: idx_t, c: idx_l};
            end
            else if (b_tl && !b_i)
            begin
                tris.v0 = b_t && b_l && tri_ok(s_tl, s_top, s_left, max_step);
                tris.t0 = '{a: idx_tl, b: idx_t, c: idx_l};
            end
            else if (b_i && b_tl)
            begin
                tris.v0 = b_l && tri_ok(s_cur, s_tl, s_left, max_step);
                tris.t0 = '{a: idx_i, b: idx_tl, c: idx_l};
                tris.v1 = b_t && tri_ok(s_cur, s_tl, s_top, max_step);
                tris.t1 = '{a: idx_i, b: idx_tl, c: idx_t};
            end
        end
    end

endmodule

@@ sv/dgbt_out_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgbt_out_queue
// Small result queue: takes zero, one or two triangles a cycle, hands out
// one a cycle while out_ready holds, and marks each sample's last triangle.
// ----------------------------------------------------------------------------
module dgbt_out_queue import dgbt_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  tri_pair_t tris,
    output logic      room2,      // space for two more entries
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    out_item_t         mem [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_next;
    logic [Q_CW-1:0]   count_reg;
    logic [Q_CW-1:0]   count_next;
    logic [1:0]        n_push;
    logic              pop;
    out_item_t         e0;
    out_item_t         e1;

    // Compact the pair: the first valid triangle goes first
    assign n_push = push ? (2'(tris.v0) + 2'(tris.v1)) : 2'd0;
    assign e0     = '{corners: (tris.v0 ? tris.t0 : tris.t1),
                      last: !(tris.v0 && tris.v1)};
    assign e1     = '{corners: tris.t1, last: 1'b1};
    assign pop    = out_valid && out_ready;

    // Storage
    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            mem[wr_ptr_reg] <= e0;
        end
        if (n_push == 2'd2)
        begin
            mem[wr_ptr_reg + Q_AW'(1)] <= e1;
        end
    end

    // Pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + Q_AW'(n_push);
        rd_ptr_next = rd_ptr_reg + Q_AW'(pop);
        count_next  = count_reg + Q_CW'(n_push) - Q_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign room2     = count_reg <= Q_CW'(Q_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_item  = mem[rd_ptr_reg];

endmodule
